[hdl/mlpdc_pkg.sv]
package mlpdc_pkg;

  localparam int N_INPUTS_DEF  = 256;
  localparam int N_HIDDEN_DEF  = 32;
  localparam int N_OUTPUTS_DEF = 10;

  localparam int WIDX_W = 14;
  localparam int VAL_W  = 16;
  localparam int ACC_W  = 48;

  localparam logic signed [VAL_W-1:0] BIAS_ONE = 16'sd16384;

  // per-step decay factor e^(-1/16), scaled by 2^32
  localparam logic [63:0] SIG_STEP = 64'd4034748382;

  typedef enum logic [1:0] {
    CMD_W1    = 2'd0,
    CMD_W2    = 2'd1,
    CMD_PIXEL = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_acc;   // load accumulator with the product of this beat
    logic mac;       // accumulate the registered product
    logic l2;        // layer 2 operands (weights times hidden)
    logic bias;      // bias input in place of the pixel
    logic act_wr;    // write hidden activation from accumulator
    logic out_eval;  // compare layer-2 sigmoid with best
    logic out_first; // first output neuron
  } dp_cmd_t;

  // Sigmoid table over [-8,8) in 1/16 steps, Q0.16. Evaluated at elaboration
  // only; the quotient comes from a restoring long division.
  function automatic logic [255:0][15:0] sig_lut_build();
    logic [255:0][15:0] tbl;
    logic [63:0]        p;
    logic [63:0]        den;
    logic [63:0]        num;
    logic [63:0]        pos;
    logic [63:0]        rem;
    tbl = '0;
    p = 64'h1_0000_0000;
    for (int k = 0; k <= 128; k++) begin
      if (k > 0) begin
        p = (p * SIG_STEP + 64'h8000_0000) >> 32;
      end
      den = 64'h1_0000_0000 + p;
      num = 64'h1_0000_0000_0000 + (den >> 1);
      pos = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem    = rem - den;
          pos[b] = 1'b1;
        end
      end
      if (k < 128) begin
        tbl[128 + k] = (pos > 64'd65535) ? 16'hFFFF : pos[15:0];
      end
      if (k > 0) begin
        tbl[128 - k] = 16'(64'd65536 - pos);
      end
    end
    return tbl;
  endfunction

endpackage

[hdl/mlpdc_ctrl.sv]
module mlpdc_ctrl #(
  parameter int N_INPUTS  = mlpdc_pkg::N_INPUTS_DEF,
  parameter int N_HIDDEN  = mlpdc_pkg::N_HIDDEN_DEF,
  parameter int N_OUTPUTS = mlpdc_pkg::N_OUTPUTS_DEF,
  parameter int PC_W      = $clog2(N_INPUTS + 1),
  parameter int HW        = $clog2(N_HIDDEN + 1),
  parameter int OW        = $clog2(N_OUTPUTS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PC_W-1:0]     n_px,
  input  logic                out_stall,
  output logic                busy,
  output logic                out_valid,
  output mlpdc_pkg::dp_cmd_t  cmd,
  output logic [PC_W-1:0]     col,
  output logic [HW-1:0]       hrow,
  output logic [OW-1:0]       orow
);
  import mlpdc_pkg::*;

  // Read address presented in state; memory read data, product and
  // accumulator are registered in that order.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_L1   = 6'b000010,
    S_L1W  = 6'b000100,
    S_L2   = 6'b001000,
    S_L2W  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] col_r, col_nxt, n_r, n_nxt;
  logic [HW-1:0]   h_r, h_nxt;
  logic [OW-1:0]   o_r, o_nxt;
  logic [2:0]      wait_r, wait_nxt;
  logic [1:0]      p1_r, p1_nxt;   // issue pipeline: valid, first
  logic [1:0]      p2_r, p2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      n_r     <= '0;
      h_r     <= '0;
      o_r     <= '0;
      wait_r  <= '0;
      p1_r    <= '0;
      p2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      n_r     <= n_nxt;
      h_r     <= h_nxt;
      o_r     <= o_nxt;
      wait_r  <= wait_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    n_nxt     = n_r;
    h_nxt     = h_r;
    o_nxt     = o_r;
    wait_nxt  = wait_r;
    p1_nxt    = 2'b00;
    p2_nxt    = p1_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt     = n_px;
          col_nxt   = '0;
          h_nxt     = '0;
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        // column n_r stands for the bias
        p1_nxt = {1'b1, (col_r == '0)};
        if (col_r == n_r) begin
          col_nxt   = '0;
          wait_nxt  = 3'd3;
          state_nxt = S_L1W;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      S_L1W: begin
        wait_nxt = wait_r - 1'b1;
        if (wait_r == 3'd1) begin
          cmd.act_wr = 1'b1;
          if (h_r == HW'(N_HIDDEN - 1)) begin
            h_nxt     = '0;
            o_nxt     = '0;
            state_nxt = S_L2;
          end else begin
            h_nxt     = h_r + 1'b1;
            state_nxt = S_L1;
          end
        end
      end
      S_L2: begin
        p1_nxt = {1'b1, (h_r == '0)};
        if (h_r == HW'(N_HIDDEN - 1)) begin
          h_nxt     = '0;
          wait_nxt  = 3'd3;
          state_nxt = S_L2W;
        end else begin
          h_nxt = h_r + 1'b1;
        end
      end
      S_L2W: begin
        wait_nxt = wait_r - 1'b1;
        if (wait_r == 3'd1) begin
          cmd.out_eval  = 1'b1;
          cmd.out_first = (o_r == '0);
          if (o_r == OW'(N_OUTPUTS - 1)) begin
            state_nxt = S_OUT;
          end else begin
            o_nxt     = o_r + 1'b1;
            state_nxt = S_L2;
          end
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.l2      = (state_r == S_L2) || (state_r == S_L2W);
    cmd.bias    = (state_r == S_L1) && (col_r == n_r);
    cmd.mac     = p2_r[1] && !p2_r[0];
    cmd.clr_acc = p2_r[1] && p2_r[0];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign col       = col_r;
  assign hrow      = h_r;
  assign orow      = o_r;

endmodule

[hdl/mlpdc_dp.sv]
module mlpdc_dp #(
  parameter int N_INPUTS  = mlpdc_pkg::N_INPUTS_DEF,
  parameter int N_HIDDEN  = mlpdc_pkg::N_HIDDEN_DEF,
  parameter int N_OUTPUTS = mlpdc_pkg::N_OUTPUTS_DEF,
  parameter int PC_W      = $clog2(N_INPUTS + 1),
  parameter int HW        = $clog2(N_HIDDEN + 1),
  parameter int OW        = $clog2(N_OUTPUTS + 1)
) (
  input  logic                           clk,
  input  logic                           w1_we,
  input  logic                           w2_we,
  input  logic                           px_we,
  input  logic [mlpdc_pkg::WIDX_W-1:0]   widx,
  input  logic [PC_W-1:0]                px_addr,
  input  logic signed [mlpdc_pkg::VAL_W-1:0] wval,
  input  mlpdc_pkg::dp_cmd_t             cmd,
  input  logic [PC_W-1:0]                col,
  input  logic [HW-1:0]                  hrow,
  input  logic [OW-1:0]                  orow,
  output logic [3:0]                     best_idx,
  output logic [15:0]                    best_score
);
  import mlpdc_pkg::*;

  localparam int W1_SIZE = N_HIDDEN * (N_INPUTS + 1);
  localparam int W2_SIZE = N_OUTPUTS * N_HIDDEN;
  localparam int W1A     = $clog2(W1_SIZE);
  localparam int W2A     = $clog2(W2_SIZE);
  localparam int PXA     = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
  localparam int HA      = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;

  localparam logic [255:0][15:0] SIG_LUT = sig_lut_build();

  logic signed [VAL_W-1:0] w1_mem [W1_SIZE];
  logic signed [VAL_W-1:0] w2_mem [W2_SIZE];
  logic signed [VAL_W-1:0] px_mem [N_INPUTS];
  logic        [15:0]      act_mem [N_HIDDEN];

  logic signed [VAL_W-1:0] w1_q, w2_q, px_q;
  logic        [15:0]      act_q;
  logic                    l2_q, bias_q;
  logic signed [33:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [W1A-1:0]          w1_ra;
  logic [W2A-1:0]          w2_ra;
  logic [15:0]             sig_v;
  logic signed [ACC_W-1:0] t;

  assign w1_ra = W1A'(hrow * (N_INPUTS + 1) + (cmd.bias ? N_INPUTS : col));
  assign w2_ra = W2A'(orow * N_HIDDEN + hrow);

  always_ff @(posedge clk) begin
    if (w1_we) w1_mem[widx[W1A-1:0]] <= wval;
    w1_q <= w1_mem[w1_ra];
  end

  always_ff @(posedge clk) begin
    if (w2_we) w2_mem[widx[W2A-1:0]] <= wval;
    w2_q <= w2_mem[w2_ra];
  end

  always_ff @(posedge clk) begin
    if (px_we) px_mem[px_addr[PXA-1:0]] <= wval;
    px_q <= px_mem[col[PXA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.act_wr) act_mem[hrow[HA-1:0]] <= sig_v;
    act_q <= act_mem[hrow[HA-1:0]];
  end

  always_ff @(posedge clk) begin
    l2_q   <= cmd.l2;
    bias_q <= cmd.bias;
    if (l2_q) begin
      prod_r <= 34'(w2_q * $signed({1'b0, act_q}));
    end else begin
      prod_r <= 34'(w1_q * (bias_q ? BIAS_ONE : px_q));
    end
    if (cmd.clr_acc)  acc_r <= ACC_W'(prod_r);
    else if (cmd.mac) acc_r <= acc_r + ACC_W'(prod_r);
  end

  // Sigmoid index: floor(acc / 2^frac) + 128, saturated.
  always_comb begin
    if (cmd.l2) t = acc_r + (ACC_W'(128) <<< 24);
    else        t = acc_r + (ACC_W'(128) <<< 22);
    if (t < 0) begin
      sig_v = SIG_LUT[0];
    end else if (cmd.l2) begin
      sig_v = ((t >>> 24) > 255) ? SIG_LUT[255] : SIG_LUT[t[31:24]];
    end else begin
      sig_v = ((t >>> 22) > 255) ? SIG_LUT[255] : SIG_LUT[t[29:22]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_eval && (cmd.out_first || sig_v > best_score)) begin
      best_idx   <= 4'(orow);
      best_score <= sig_v;
    end
  end

endmodule

[hdl/mlp_digit_classifier.sv]
// Compute: one shared MAC, one product a cycle while a neuron's
//   operands are issued, with a drain after each neuron before the
//   next one starts.
// Throughput: weight and non-last pixel beats are taken one per cycle;
//   a last beat blocks input until its result is taken.
// Reset: rst_n synchronous active low clears control, pixel count and
//   model_ready; weight, pixel and activation memories hold no reset.
module mlp_digit_classifier #(
  parameter int N_INPUTS  = mlpdc_pkg::N_INPUTS_DEF,
  parameter int N_HIDDEN  = mlpdc_pkg::N_HIDDEN_DEF,
  parameter int N_OUTPUTS = mlpdc_pkg::N_OUTPUTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_cmd,
  input  logic [mlpdc_pkg::WIDX_W-1:0]     in_weight_index,
  input  logic signed [mlpdc_pkg::VAL_W-1:0] in_value,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [3:0]                       out_digit,
  output logic [15:0]                      out_score,
  output logic                             out_status
);
  import mlpdc_pkg::*;

  localparam int PC_W    = $clog2(N_INPUTS + 1);
  localparam int HW      = $clog2(N_HIDDEN + 1);
  localparam int OW      = $clog2(N_OUTPUTS + 1);
  localparam int W1_SIZE = N_HIDDEN * (N_INPUTS + 1);
  localparam int W2_SIZE = N_OUTPUTS * N_HIDDEN;

  logic            ready_r;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            nr_valid_r;   // not-ready answer pending
  logic            busy, calc_valid, acc;
  logic            is_px, px_take, start;
  dp_cmd_t         cmd;
  logic [PC_W-1:0] col;
  logic [HW-1:0]   hrow;
  logic [OW-1:0]   orow;
  logic [3:0]      best_idx;
  logic [15:0]     best_score;

  // hold input while a classification runs or a not-ready answer is out
  assign in_stall = busy || nr_valid_r;
  assign acc      = in_valid && !in_stall;
  assign is_px    = (cmd_t'(in_cmd) == CMD_PIXEL);
  assign px_take  = acc && is_px && (pc_r < PC_W'(N_INPUTS));
  assign start    = acc && is_px && in_last && ready_r;

  always_comb begin
    pc_nxt = pc_r;
    if (px_take) pc_nxt = pc_r + 1'b1;
    if (acc && is_px && in_last) pc_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r    <= 1'b0;
      pc_r       <= '0;
      nr_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ready_r <= cfg_wdata;
      pc_r <= pc_nxt;
      if (acc && is_px && in_last && !ready_r) nr_valid_r <= 1'b1;
      else if (!out_stall)                     nr_valid_r <= 1'b0;
    end
  end

  mlpdc_ctrl #(
    .N_INPUTS (N_INPUTS),
    .N_HIDDEN (N_HIDDEN),
    .N_OUTPUTS(N_OUTPUTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .n_px     (px_take ? pc_r + 1'b1 : pc_r),
    .out_stall(out_stall),
    .busy     (busy),
    .out_valid(calc_valid),
    .cmd      (cmd),
    .col      (col),
    .hrow     (hrow),
    .orow     (orow)
  );

  mlpdc_dp #(
    .N_INPUTS (N_INPUTS),
    .N_HIDDEN (N_HIDDEN),
    .N_OUTPUTS(N_OUTPUTS)
  ) u_dp (
    .clk       (clk),
    .w1_we     (acc && cmd_t'(in_cmd) == CMD_W1 && in_weight_index < WIDX_W'(W1_SIZE)),
    .w2_we     (acc && cmd_t'(in_cmd) == CMD_W2 && in_weight_index < WIDX_W'(W2_SIZE)),
    .px_we     (px_take),
    .widx      (in_weight_index),
    .px_addr   (pc_r),
    .wval      (in_value),
    .cmd       (cmd),
    .col       (col),
    .hrow      (hrow),
    .orow      (orow),
    .best_idx  (best_idx),
    .best_score(best_score)
  );

  assign out_valid  = calc_valid || nr_valid_r;
  assign out_digit  = nr_valid_r ? 4'd0 : best_idx;
  assign out_score  = nr_valid_r ? 16'd0 : best_score;
  assign out_status = nr_valid_r;

endmodule
